>>> sv/cfr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the frame receiver.
package cfr_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 64;
  localparam int unsigned EMIT_CAP        = 64;

  localparam logic [7:0]  SYNC_FIRST      = 8'hBA;
  localparam logic [7:0]  SYNC_SECOND     = 8'hCE;
  localparam logic [16:0] OVERHEAD_BYTES  = 17'd10;
  localparam logic [6:0]  MAX_LEN_RESET   = 7'd64;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd0;
  localparam logic [1:0] CFG_FILTER_ENABLE = 2'd1;
  localparam logic [1:0] CFG_WANT_CLASS    = 2'd2;
  localparam logic [1:0] CFG_WANT_ID       = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       restart;     // rewind write position to the frame start
    logic       store;       // write rx byte into the frame store
    logic       len_lo;
    logic       len_hi;
    logic       set_class;
    logic       set_id;      // also seeds the checksum
    logic       pay_step;    // count a payload byte, add finished words
    logic [2:0] ck_byte;     // capture checksum byte 0, 1 or 2
    logic       start_emit;  // latch frame total, rewind read position
    logic       rd_issue;    // read store at the read position
    logic       out_load;    // move read data into the output register
  } cfr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sync1;
    logic sync2;
    logic too_big;
    logic len_zero;
    logic pay_done;
    logic ck_ok;
    logic filt_ok;
    logic emit_last;
    logic out_free;
  } cfr_sts_t;

endpackage

>>> sv/casic_frame_receiver_top.sv
// Top level: CASIC binary frame receiver with checksum check and class/id filter.
// Throughput: one received byte per cycle while a frame is parsed.
// A verified frame's first beat: store read, then output load once the output register is free.
// Emission: each beat is a registered store read, then an output register load;
// input is stalled for the whole burst, which is as long as the frame.
// Reset: parser returns to sync hunt, counters clear, config takes defaults; store is not cleared.
module casic_frame_receiver_top import cfr_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       abort,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic [5:0] byte_index,
  output logic       last,
  output logic [7:0] frame_class,
  output logic [7:0] frame_id,
  output logic [6:0] frame_total
);

  cfr_cmd_t cmd;
  cfr_sts_t sts;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .abort    (abort),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfr_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .byte_index  (byte_index),
    .last        (last),
    .frame_class (frame_class),
    .frame_id    (frame_id),
    .frame_total (frame_total)
  );

endmodule

>>> sv/cfr_datapath.sv
// Datapath: config registers, header fields, checksum, frame store and output register.
module cfr_datapath import cfr_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [7:0] rx_byte,
  input  cfr_cmd_t   cmd,
  output cfr_sts_t   sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic [5:0] byte_index,
  output logic       last,
  output logic [7:0] frame_class,
  output logic [7:0] frame_id,
  output logic [6:0] frame_total
);

  localparam int unsigned STORE_DEPTH = (FRAME_DEPTH < EMIT_CAP) ? FRAME_DEPTH : EMIT_CAP;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam logic [6:0]  STORE_LIM   = 7'(STORE_DEPTH);

  logic [6:0]  max_frame_len;
  logic        filter_enable;
  logic [7:0]  want_class;
  logic [7:0]  want_id;

  logic [15:0] payload_length;
  logic [5:0]  payload_count;
  logic [5:0]  count_next;
  logic [31:0] running_sum;
  logic [23:0] got_check_bytes;
  logic [23:0] word_tail;
  logic [7:0]  msg_class;
  logic [7:0]  msg_ident;
  logic [6:0]  write_pos;
  logic [6:0]  rd_pos;
  logic [6:0]  total;
  logic [7:0]  rd_data;
  logic [6:0]  limit;
  logic [16:0] len_sum;

  logic [7:0]  frame_store [STORE_DEPTH];

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
      filter_enable <= 1'b0;
      want_class    <= 8'd0;
      want_id       <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_FRAME_LEN: max_frame_len <= cfg_data[6:0];
        CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        CFG_WANT_CLASS:    want_class    <= cfg_data;
        CFG_WANT_ID:       want_id       <= cfg_data;
      endcase
    end
  end

  // Length limit and oversize test, no 16-bit wrap
  assign limit   = (max_frame_len < STORE_LIM) ? max_frame_len : STORE_LIM;
  assign len_sum = {1'b0, rx_byte, payload_length[7:0]} + OVERHEAD_BYTES;
  assign count_next = payload_count + 6'd1;

  // Header fields, payload count and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length  <= 16'd0;
      payload_count   <= 6'd0;
      running_sum     <= 32'd0;
      got_check_bytes <= 24'd0;
      msg_class       <= 8'd0;
      msg_ident       <= 8'd0;
      word_tail       <= 24'd0;
    end else begin
      if (cmd.len_lo) payload_length <= {8'd0, rx_byte};
      if (cmd.len_hi) payload_length <= {rx_byte, payload_length[7:0]};
      if (cmd.set_class) msg_class <= rx_byte;
      if (cmd.set_id) begin
        msg_ident     <= rx_byte;
        running_sum   <= {rx_byte, msg_class, payload_length};
        payload_count <= 6'd0;
      end
      if (cmd.pay_step) begin
        payload_count <= count_next;
        word_tail     <= {rx_byte, word_tail[23:8]};
        if (count_next[1:0] == 2'b00) running_sum <= running_sum + {rx_byte, word_tail};
      end
      if (cmd.ck_byte[0]) got_check_bytes <= {16'd0, rx_byte};
      if (cmd.ck_byte[1]) got_check_bytes[15:8] <= rx_byte;
      if (cmd.ck_byte[2]) got_check_bytes[23:16] <= rx_byte;
    end
  end

  // Write and read positions
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= 7'd0;
      rd_pos    <= 7'd0;
      total     <= 7'd0;
    end else begin
      if (cmd.restart) write_pos <= 7'd0;
      else if (cmd.store) write_pos <= write_pos + 7'd1;
      if (cmd.start_emit) begin
        total  <= write_pos + 7'd1;
        rd_pos <= 7'd0;
      end else if (cmd.out_load) begin
        rd_pos <= rd_pos + 7'd1;
      end
    end
  end

  // Frame store, registered read
  always_ff @(posedge clk) begin
    if (cmd.store && (write_pos < STORE_LIM)) frame_store[write_pos[AW-1:0]] <= rx_byte;
    if (cmd.rd_issue) rd_data <= frame_store[rd_pos[AW-1:0]];
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_byte  <= rd_data;
      byte_index  <= rd_pos[5:0];
      last        <= sts.emit_last;
      frame_class <= msg_class;
      frame_id    <= msg_ident;
      frame_total <= total;
    end
  end

  // Status to controller
  always_comb begin
    sts.sync1     = (rx_byte == SYNC_FIRST);
    sts.sync2     = (rx_byte == SYNC_SECOND);
    sts.too_big   = (len_sum > {10'd0, limit});
    sts.len_zero  = (payload_length == 16'd0);
    sts.pay_done  = ({10'd0, count_next} >= payload_length);
    sts.ck_ok     = ({rx_byte, got_check_bytes} == running_sum);
    sts.filt_ok   = !filter_enable || ((msg_class == want_class) && (msg_ident == want_id));
    sts.emit_last = ((rd_pos + 7'd1) == total);
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule

>>> sv/cfr_ctrl.sv
// Controller: frame parse sequence and emission sequence.
module cfr_ctrl import cfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     abort,
  input  cfr_sts_t sts,
  output cfr_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_HUNT1   = 13'b0000000000001,
    S_HUNT2   = 13'b0000000000010,
    S_LEN_LO  = 13'b0000000000100,
    S_LEN_HI  = 13'b0000000001000,
    S_CLASS   = 13'b0000000010000,
    S_ID      = 13'b0000000100000,
    S_BODY    = 13'b0000001000000,
    S_CK0     = 13'b0000010000000,
    S_CK1     = 13'b0000100000000,
    S_CK2     = 13'b0001000000000,
    S_CK3     = 13'b0010000000000,
    S_READ    = 13'b0100000000000,
    S_LOAD    = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   take;

  // Stall input while the stored frame streams out
  assign in_stall = (state == S_READ) || (state == S_LOAD);
  assign accept   = in_valid && !in_stall;
  assign take     = accept && !abort;

  always_ff @(posedge clk) begin
    if (rst) state <= S_HUNT1;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    if (accept && abort) begin
      cmd.restart = 1'b1;
      state_next  = S_HUNT1;
    end else begin
      unique case (state)
        S_HUNT1: begin
          if (take && sts.sync1) begin
            cmd.store  = 1'b1;
            state_next = S_HUNT2;
          end
        end
        S_HUNT2: begin
          if (take) begin
            if (sts.sync2) begin
              cmd.store  = 1'b1;
              state_next = S_LEN_LO;
            end else if (!sts.sync1) begin
              cmd.restart = 1'b1;
              state_next  = S_HUNT1;
            end
          end
        end
        S_LEN_LO: begin
          if (take) begin
            cmd.store  = 1'b1;
            cmd.len_lo = 1'b1;
            state_next = S_LEN_HI;
          end
        end
        S_LEN_HI: begin
          if (take) begin
            cmd.store  = 1'b1;
            cmd.len_hi = 1'b1;
            if (sts.too_big) begin
              cmd.restart = 1'b1;
              state_next  = S_HUNT1;
            end else begin
              state_next = S_CLASS;
            end
          end
        end
        S_CLASS: begin
          if (take) begin
            cmd.store     = 1'b1;
            cmd.set_class = 1'b1;
            state_next    = S_ID;
          end
        end
        S_ID: begin
          if (take) begin
            cmd.store  = 1'b1;
            cmd.set_id = 1'b1;
            state_next = sts.len_zero ? S_CK0 : S_BODY;
          end
        end
        S_BODY: begin
          if (take) begin
            cmd.store    = 1'b1;
            cmd.pay_step = 1'b1;
            if (sts.pay_done) state_next = S_CK0;
          end
        end
        S_CK0: begin
          if (take) begin
            cmd.store      = 1'b1;
            cmd.ck_byte[0] = 1'b1;
            state_next     = S_CK1;
          end
        end
        S_CK1: begin
          if (take) begin
            cmd.store      = 1'b1;
            cmd.ck_byte[1] = 1'b1;
            state_next     = S_CK2;
          end
        end
        S_CK2: begin
          if (take) begin
            cmd.store      = 1'b1;
            cmd.ck_byte[2] = 1'b1;
            state_next     = S_CK3;
          end
        end
        S_CK3: begin
          if (take) begin
            cmd.store   = 1'b1;
            cmd.restart = 1'b1;
            if (sts.ck_ok && sts.filt_ok) begin
              cmd.start_emit = 1'b1;
              state_next     = S_READ;
            end else begin
              state_next = S_HUNT1;
            end
          end
        end
        S_READ: begin
          cmd.rd_issue = 1'b1;
          state_next   = S_LOAD;
        end
        S_LOAD: begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = sts.emit_last ? S_HUNT1 : S_READ;
          end
        end
        default: begin
          state_next = S_HUNT1;
        end
      endcase
    end
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_LOAD)
    else $error("store read not followed by output load");
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && sts.emit_last |=> state == S_HUNT1)
    else $error("burst did not end after last beat");
  a_good_frame_emits: assert property (@(posedge clk) disable iff (rst)
    state == S_CK3 && take && sts.ck_ok && sts.filt_ok |=> state == S_READ)
    else $error("verified frame not emitted");

endmodule

>>> tb/casic_frame_checker.sv
// Checker for the frame receiver: predicts verified frame beats and compares the output channel.
`timescale 1ns / 100ps
module casic_frame_checker import cfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       abort,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] frame_byte,
  input  logic [5:0] byte_index,
  input  logic       last,
  input  logic [7:0] frame_class,
  input  logic [7:0] frame_id,
  input  logic [6:0] frame_total,
  output int         fail_count,
  output int         pending
);

  localparam int unsigned HDR_LEN  = 6;
  localparam int unsigned WORD_LEN = 4;

  typedef enum logic [3:0] {
    SEEK_SYNC1, SEEK_SYNC2, GET_LEN_LO, GET_LEN_HI, GET_CLASS, GET_ID,
    GET_PAYLOAD, GET_CK0, GET_CK1, GET_CK2, GET_CK3
  } rx_phase_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [5:0] idx;
    logic       lst;
    logic [7:0] cls;
    logic [7:0] id;
    logic [6:0] tot;
  } frame_beat_t;

  // Register copies
  logic [6:0]  cfg_max_len;
  logic        cfg_filter;
  logic [7:0]  cfg_class;
  logic [7:0]  cfg_id;

  // Parser copy
  rx_phase_t   phase;
  logic [15:0] pay_len;
  logic [15:0] pay_cnt;
  logic [31:0] csum;
  logic [23:0] ck_bytes;
  logic [7:0]  cur_class;
  logic [7:0]  cur_id;
  logic [7:0]  fstore [FRAME_DEPTH_DEF];
  logic [6:0]  wr_ptr;

  frame_beat_t verified_frame_q [$];
  int          err_cnt = 0;
  int          depth_cnt = 0;

  assign fail_count = err_cnt;
  assign pending    = depth_cnt;

  function automatic logic [7:0] stored(input int unsigned pos);
    return (pos < FRAME_DEPTH_DEF) ? fstore[pos] : 8'h00;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    if (wr_ptr < FRAME_DEPTH_DEF) fstore[wr_ptr] = b;
    wr_ptr = wr_ptr + 7'd1;
  endtask

  task automatic rehunt();
    phase  = SEEK_SYNC1;
    wr_ptr = 7'd0;
  endtask

  // Advance the parser by one accepted beat; queue the frame when it verifies
  task automatic parse_rx_beat(input logic [7:0] b, input logic ab);
    int unsigned lim;
    int unsigned len_plus;
    int unsigned p;
    int unsigned tot;
    int unsigned i;
    frame_beat_t w;
    if (ab) begin
      rehunt();
    end else begin
      case (phase)
        SEEK_SYNC1: begin
          if (b == SYNC_FIRST) begin
            wr_ptr = 7'd0;
            put_byte(b);
            phase = SEEK_SYNC2;
          end
        end
        SEEK_SYNC2: begin
          if (b == SYNC_SECOND) begin
            put_byte(b);
            phase = GET_LEN_LO;
          end else if (b != SYNC_FIRST) begin
            rehunt();
          end
        end
        GET_LEN_LO: begin
          put_byte(b);
          pay_len = {8'h00, b};
          phase = GET_LEN_HI;
        end
        GET_LEN_HI: begin
          put_byte(b);
          pay_len = {b, pay_len[7:0]};
          lim = 32'(cfg_max_len);
          if (lim > FRAME_DEPTH_DEF) lim = FRAME_DEPTH_DEF;
          if (lim > EMIT_CAP) lim = EMIT_CAP;
          // no 16-bit wrap on the overflow test
          len_plus = 32'(pay_len) + 32'(OVERHEAD_BYTES);
          if (len_plus > lim) rehunt();
          else phase = GET_CLASS;
        end
        GET_CLASS: begin
          put_byte(b);
          cur_class = b;
          phase = GET_ID;
        end
        GET_ID: begin
          put_byte(b);
          cur_id  = b;
          csum    = {cur_id, cur_class, pay_len};
          pay_cnt = 16'd0;
          phase   = (pay_len == 16'd0) ? GET_CK0 : GET_PAYLOAD;
        end
        GET_PAYLOAD: begin
          put_byte(b);
          pay_cnt = pay_cnt + 16'd1;
          // add each finished little-endian word
          if (pay_cnt[1:0] == 2'd0) begin
            p = HDR_LEN + 32'(pay_cnt) - WORD_LEN;
            csum = csum + {stored(p + 3), stored(p + 2), stored(p + 1), stored(p)};
          end
          if (pay_cnt >= pay_len) phase = GET_CK0;
        end
        GET_CK0: begin
          put_byte(b);
          ck_bytes = {16'h0000, b};
          phase = GET_CK1;
        end
        GET_CK1: begin
          put_byte(b);
          ck_bytes[15:8] = b;
          phase = GET_CK2;
        end
        GET_CK2: begin
          put_byte(b);
          ck_bytes[23:16] = b;
          phase = GET_CK3;
        end
        GET_CK3: begin
          put_byte(b);
          if ({b, ck_bytes} == csum &&
              (!cfg_filter || (cur_class == cfg_class && cur_id == cfg_id))) begin
            tot = (32'(wr_ptr) > EMIT_CAP) ? EMIT_CAP : 32'(wr_ptr);
            for (i = 0; i < tot; i++) begin
              w.fbyte = stored(i);
              w.idx   = 6'(i);
              w.lst   = (i + 1 == tot);
              w.cls   = cur_class;
              w.id    = cur_id;
              w.tot   = 7'(tot);
              verified_frame_q.push_back(w);
            end
          end
          rehunt();
        end
        default: rehunt();
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // Compare one output beat with the oldest predicted beat
  task automatic check_beat();
    frame_beat_t w;
    if (verified_frame_q.size() == 0) begin
      $error("unexpected frame beat: frame_byte %0h byte_index %0d", frame_byte, byte_index);
      err_cnt++;
    end else begin
      w = verified_frame_q.pop_front();
      check_field("frame_byte", 32'(w.fbyte), 32'(frame_byte));
      check_field("byte_index", 32'(w.idx), 32'(byte_index));
      check_field("last", 32'(w.lst), 32'(last));
      check_field("frame_class", 32'(w.cls), 32'(frame_class));
      check_field("frame_id", 32'(w.id), 32'(frame_id));
      check_field("frame_total", 32'(w.tot), 32'(frame_total));
    end
  endtask

  // Watch config, input and output channels
  always @(posedge clk) begin
    if (rst) begin
      cfg_max_len = MAX_LEN_RESET;
      cfg_filter  = 1'b0;
      cfg_class   = 8'h00;
      cfg_id      = 8'h00;
      phase       = SEEK_SYNC1;
      pay_len     = 16'd0;
      pay_cnt     = 16'd0;
      csum        = 32'd0;
      ck_bytes    = 24'd0;
      cur_class   = 8'h00;
      cur_id      = 8'h00;
      wr_ptr      = 7'd0;
      verified_frame_q.delete();
    end else begin
      if (out_valid && !out_stall) check_beat();
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_FRAME_LEN: cfg_max_len = cfg_data[6:0];
          CFG_FILTER_ENABLE: cfg_filter  = cfg_data[0];
          CFG_WANT_CLASS:    cfg_class   = cfg_data;
          CFG_WANT_ID:       cfg_id      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_rx_beat(rx_byte, abort);
    end
    depth_cnt = verified_frame_q.size();
  end

endmodule

>>> tb/casic_frame_receiver_top_tb.sv
// Testbench top for the frame receiver: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 100ps
module casic_frame_receiver_top_tb import cfr_pkg::*;;

  typedef struct packed {
    logic [7:0] data;
    logic       stop;
  } rx_beat_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       abort;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       last;
  logic [7:0] frame_class;
  logic [7:0] frame_id;
  logic [6:0] frame_total;
  int         fail_count;
  int         pending;

  rx_beat_t   tx_q [$];
  int         frame_bytes = 0;
  int         hold_cycles = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;

  // Mirrors of the register settings, used to shape frames
  logic [6:0] cur_max = MAX_LEN_RESET;
  logic       cur_filter = 1'b0;
  logic [7:0] cur_class = 8'h00;
  logic [7:0] cur_id = 8'h00;

  casic_frame_receiver_top u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .rx_byte, .abort,
    .out_valid, .out_stall, .frame_byte, .byte_index, .last,
    .frame_class, .frame_id, .frame_total
  );

  casic_frame_checker u_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .rx_byte, .abort,
    .out_valid, .out_stall, .frame_byte, .byte_index, .last,
    .frame_class, .frame_id, .frame_total,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int payload_room();
    int lim;
    lim = (cur_max > FRAME_DEPTH_DEF) ? FRAME_DEPTH_DEF : cur_max;
    return lim - 10;
  endfunction

  task automatic push_rx(input logic [7:0] b, input logic ab);
    rx_beat_t bt;
    bt.data = b;
    bt.stop = ab;
    tx_q.push_back(bt);
  endtask

  // Queue a whole frame with a correct or corrupted checksum
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input bit bad_ck);
    logic [7:0]  body [$];
    logic [31:0] sum;
    int          i;
    sum = {id, cls, len};
    for (i = 0; i < len; i++) body.push_back(8'($urandom));
    for (i = 0; i + 3 < len; i += 4) sum += {body[i+3], body[i+2], body[i+1], body[i]};
    if (bad_ck) sum ^= 32'd1 << $urandom_range(0, 31);
    push_rx(SYNC_FIRST, 1'b0);
    push_rx(SYNC_SECOND, 1'b0);
    push_rx(len[7:0], 1'b0);
    push_rx(len[15:8], 1'b0);
    push_rx(cls, 1'b0);
    push_rx(id, 1'b0);
    foreach (body[k]) push_rx(body[k], 1'b0);
    for (i = 0; i < 4; i++) push_rx(sum[8*i +: 8], 1'b0);
    frame_bytes += len + 10;
  endtask

  // Queue one random piece of traffic: mostly good frames, the rest broken ones
  task automatic push_random_item();
    int          kind;
    int          room;
    int          len;
    int          mark;
    int          cut;
    logic [15:0] len16;
    logic [7:0]  cls;
    logic [7:0]  id;
    room = payload_room();
    kind = $urandom_range(0, 99);
    if (cur_filter && $urandom_range(0, 1) == 1) begin
      cls = cur_class;
      id  = cur_id;
    end else begin
      cls = 8'($urandom);
      id  = 8'($urandom);
    end
    if (room < 0) len = $urandom_range(0, 3);
    else if ($urandom_range(0, 3) != 0) len = $urandom_range(0, (room < 12) ? room : 12);
    else len = $urandom_range(0, room);
    len16 = 16'(len);
    if (kind < 60) begin
      push_frame(cls, id, len16, 1'b0);
    end else if (kind < 70) begin
      push_frame(cls, id, len16, 1'b1);
    end else if (kind < 78) begin
      // oversized header; what follows is seen by the sync hunt
      if (room < 0) len16 = 16'($urandom_range(0, 8));
      else if ($urandom_range(0, 3) == 0) len16 = 16'($urandom_range(room + 1, 65535));
      else len16 = 16'(room + 1 + $urandom_range(0, 2));
      push_rx(SYNC_FIRST, 1'b0);
      push_rx(SYNC_SECOND, 1'b0);
      push_rx(len16[7:0], 1'b0);
      push_rx(len16[15:8], 1'b0);
      push_rx(cls, 1'b0);
      push_rx(id, 1'b0);
    end else if (kind < 86) begin
      // drop the tail of a frame and abort it
      mark = tx_q.size();
      push_frame(cls, id, len16, 1'b0);
      cut = $urandom_range(1, tx_q.size() - mark - 1);
      repeat (cut) void'(tx_q.pop_back());
      push_rx(8'($urandom), 1'b1);
    end else if (kind < 92) begin
      push_rx(SYNC_FIRST, 1'b0);
      push_frame(cls, id, len16, 1'b0);
    end else if (kind < 96) begin
      push_rx(SYNC_FIRST, 1'b0);
      push_rx(8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) push_rx(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic fill_random(input int amount);
    int target;
    target = frame_bytes + amount;
    while (frame_bytes < target) push_random_item();
  endtask

  // Offer every queued beat with random gaps; hold each beat while stalled
  task automatic send_all();
    rx_beat_t bt;
    int       gap;
    int       n;
    n = 0;
    while (tx_q.size() != 0) begin
      bt = tx_q.pop_front();
      if ((n % 24) == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      gap = tx_quiet ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid <= 1'b1;
      rx_byte  <= bt.data;
      abort    <= bt.stop;
      do @(posedge clk); while (in_stall);
      n++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted beat has come out, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] max_raw, input logic filt,
                            input logic [7:0] cls, input logic [7:0] id);
    write_reg(CFG_MAX_FRAME_LEN, max_raw);
    write_reg(CFG_FILTER_ENABLE, {7'd0, filt});
    write_reg(CFG_WANT_CLASS, cls);
    write_reg(CFG_WANT_ID, id);
    cur_max    = max_raw[6:0];
    cur_filter = filt;
    cur_class  = cls;
    cur_id     = id;
  endtask

  // Receiver: random stall before each beat, plus one long hold on request
  initial begin : rx_side
    int k;
    int cnt;
    cnt = 0;
    forever begin
      if (hold_cycles != 0) begin
        k = hold_cycles;
        hold_cycles = 0;
      end else begin
        if ((cnt % 32) == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        k = rx_quiet ? 0 : $urandom_range(0, 9);
      end
      repeat (k) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      cnt++;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_MAX_FRAME_LEN;
    cfg_data  = 8'h00;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    abort     = 1'b0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme bytes, repeated first sync with empty payload,
    // wrong second sync, oversized length that would wrap, abort, bad checksum
    push_rx(8'h00, 1'b0);
    push_rx(8'hFF, 1'b0);
    push_rx(SYNC_FIRST, 1'b0);
    push_frame(8'hFF, 8'h00, 16'd0, 1'b0);
    push_rx(SYNC_FIRST, 1'b0);
    push_rx(8'h55, 1'b0);
    push_rx(SYNC_FIRST, 1'b0);
    push_rx(SYNC_SECOND, 1'b0);
    push_rx(8'hF8, 1'b0);
    push_rx(8'hFF, 1'b0);
    push_rx(SYNC_FIRST, 1'b0);
    push_rx(SYNC_SECOND, 1'b0);
    push_rx(8'h02, 1'b0);
    push_rx(8'hFF, 1'b1);
    push_frame(8'h00, 8'hFF, 16'd3, 1'b1);
    push_frame(8'h5A, 8'hA5, 16'd5, 1'b0);
    send_all();

    // Defaults: random traffic
    fill_random(6);
    send_all();
    drain();

    // Filter on a random class and id, mid-size limit
    set_config(8'($urandom_range(24, 48)), 1'b1, 8'($urandom), 8'($urandom));
    fill_random(6);
    send_all();
    drain();

    // Limit above the store depth; largest frame, long receiver hold fills the block
    set_config(8'hFF, 1'b0, 8'hFF, 8'hFF);
    push_frame(8'($urandom), 8'($urandom), 16'(payload_room()), 1'b0);
    fill_random(4);
    hold_cycles = 400;
    send_all();
    drain();

    // Limit below the overhead rejects everything
    set_config(8'd5, 1'b1, 8'h00, 8'h00);
    fill_random(1);
    send_all();
    drain();

    // Smallest useful limit: only empty payloads pass
    set_config(8'd10, 1'b0, 8'h00, 8'h00);
    fill_random(1);
    send_all();
    drain();

    set_config(8'($urandom_range(10, 64)), 1'b1, 8'h00, 8'h00);
    fill_random(4);
    send_all();
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
